// ----- hdl/rgbact_pkg.sv -----
// Package: shared constants, codes and types of the RGBA component transfer block.
package rgbact_pkg;

    // Sizing of the per-channel tables and the gamma exponent.
    localparam int TABLE_DEPTH  = 256;
    localparam int MAX_EXPONENT = 15;
    localparam int IDX_W        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);
    localparam int EXP_W        = $clog2(MAX_EXPONENT + 1);
    localparam int ADDR_W       = IDX_W + 2;
    localparam int TAB_WORDS    = 4 << IDX_W;

    // Datapath widths: a 17 by 9 bit signed product and its magnitude.
    localparam int PROD_W = 26;
    localparam int DIV_W  = PROD_W - 1;
    localparam int DCNT_W = $clog2(DIV_W);
    localparam int VAL_W  = 18;

    // Division by 255 as a reciprocal multiplication: exact for magnitudes below 2^24.
    localparam int              RECIP_W   = 24;
    localparam int              RECIP_SH  = 31;
    localparam logic [RECIP_W-1:0] RECIP_255 = 24'h808081;

    // Request types.
    localparam logic [1:0] REQ_PIXEL = 2'd0;
    localparam logic [1:0] REQ_PARAM = 2'd1;
    localparam logic [1:0] REQ_TABLE = 2'd2;

    // Parameter selectors.
    localparam logic [2:0] SEL_MODE      = 3'd0;
    localparam logic [2:0] SEL_SLOPE     = 3'd1;
    localparam logic [2:0] SEL_INTERCEPT = 3'd2;
    localparam logic [2:0] SEL_AMPLITUDE = 3'd3;
    localparam logic [2:0] SEL_OFFSET    = 3'd4;
    localparam logic [2:0] SEL_EXPONENT  = 3'd5;
    localparam logic [2:0] SEL_COUNT     = 3'd6;

    // Transfer modes.
    localparam logic [2:0] MODE_IDENTITY = 3'd0;
    localparam logic [2:0] MODE_TABLE    = 3'd1;
    localparam logic [2:0] MODE_DISCRETE = 3'd2;
    localparam logic [2:0] MODE_LINEAR   = 3'd3;
    localparam logic [2:0] MODE_GAMMA    = 3'd4;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UNPRE,
        ST_XFER,
        ST_MUL,
        ST_DSTART,
        ST_DWAIT,
        ST_RDK,
        ST_RDK1,
        ST_RDW,
        ST_CLAMP,
        ST_PREM,
        ST_DONE
    } t_state;

    // Operation carried through the shared multiply-divide.
    typedef enum logic [2:0] {
        OP_UNPRE,
        OP_LIN,
        OP_GPOW,
        OP_GAMP,
        OP_TIDX,
        OP_TINT,
        OP_DIDX,
        OP_PREM
    } t_op;

    // Divider request and response.
    typedef struct packed {
        logic                     start;
        logic signed [PROD_W-1:0] dividend;
        logic [7:0]               divisor;
    } t_div_req;

    typedef struct packed {
        logic                     done;
        logic signed [PROD_W-1:0] quot;
        logic [7:0]               rem;
    } t_div_rsp;

    // Table write port.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [15:0]       data;
    } t_tab_wr;

endpackage

// ----- hdl/rgbact_div.sv -----
// Shared divider: signed dividend by an 8-bit divisor, bit-serial or by reciprocal for 255.
module rgbact_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rgbact_pkg::t_div_req i_req,
    output rgbact_pkg::t_div_rsp o_rsp
);
    import rgbact_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic             r_fmul;
    logic             r_fdiv;
    logic             r_neg;
    logic [7:0]       r_dvs;
    logic [7:0]       r_rem;
    logic [DIV_W-1:0] r_mq;
    logic [DCNT_W-1:0] r_cnt;
    logic [2*RECIP_W-1:0] r_recip;

    logic [PROD_W-1:0] abs_dividend;
    logic [8:0]        trial;
    logic              ge;
    logic              last_step;
    logic              by_255;
    logic [2*RECIP_W-RECIP_SH-1:0] fast_q;
    logic [DIV_W-1:0]  fast_rem;

    // Magnitude of the dividend, one restoring step and the reciprocal quotient.
    always_comb begin
        abs_dividend = i_req.dividend[PROD_W-1] ? PROD_W'(-i_req.dividend)
                                                : PROD_W'(i_req.dividend);
        trial     = {r_rem, r_mq[DIV_W-1]};
        ge        = (trial >= {1'b0, r_dvs});
        last_step = r_busy && (r_cnt == DCNT_W'(DIV_W - 1));
        by_255    = (i_req.divisor == 8'd255);
        fast_q    = r_recip[2*RECIP_W-1:RECIP_SH];
        fast_rem  = r_mq - DIV_W'({fast_q, 8'd0}) + DIV_W'(fast_q);
    end

    // Iteration control: 25 steps for a general divisor, two for a divisor of 255.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_fmul <= 1'b0;
            r_fdiv <= 1'b0;
        end else begin
            r_fmul <= i_req.start && by_255;
            r_fdiv <= r_fmul;
            r_done <= r_fdiv || (!i_req.start && last_step);
            if (i_req.start) begin
                r_busy <= !by_255;
            end else if (last_step) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Partial remainder and quotient shift register, or the reciprocal product.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mq  <= abs_dividend[DIV_W-1:0];
            r_rem <= 8'd0;
            r_cnt <= '0;
            r_neg <= i_req.dividend[PROD_W-1];
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? 8'(trial - {1'b0, r_dvs}) : trial[7:0];
            r_mq  <= {r_mq[DIV_W-2:0], ge};
            r_cnt <= r_cnt + 1'b1;
        end else if (r_fmul) begin
            r_recip <= {{RECIP_W{1'b0}}, r_mq[RECIP_W-1:0]} *
                       {{RECIP_W{1'b0}}, RECIP_255};
        end else if (r_fdiv) begin
            r_mq  <= DIV_W'(fast_q);
            r_rem <= fast_rem[7:0];
        end
    end

    // Quotient truncates toward zero.
    always_comb begin
        o_rsp.done = r_done;
        o_rsp.quot = r_neg ? -$signed({1'b0, r_mq}) : $signed({1'b0, r_mq});
        o_rsp.rem  = r_rem;
    end

endmodule

// ----- hdl/rgbact_table.sv -----
// Table store for all four channels: one write and one registered read per cycle.
module rgbact_table (
    input  logic                          i_clk,
    input  rgbact_pkg::t_tab_wr           i_wr,
    input  logic                          i_rd_en,
    input  logic [rgbact_pkg::ADDR_W-1:0] i_rd_addr,
    output logic [15:0]                   o_rd_data
);
    import rgbact_pkg::*;

    logic [15:0] mem [TAB_WORDS];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

endmodule

// ----- hdl/rgbact_xfer_core.sv -----
// Sequencer, parameter registers and shared multiplier of the component transfer.
module rgbact_xfer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [1:0]  i_channel,
    input  logic [2:0]  i_param_select,
    input  logic [7:0]  i_table_index,
    input  logic signed [15:0] i_load_value,
    input  logic [7:0]  i_in_red,
    input  logic [7:0]  i_in_green,
    input  logic [7:0]  i_in_blue,
    input  logic [7:0]  i_in_alpha,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic [7:0]  o_out_alpha
);
    import rgbact_pkg::*;

    t_state r_state, n_state;
    t_op    r_op;

    // Per-channel settings.
    logic [2:0]        r_mode [4];
    logic signed [15:0] r_slope [4];
    logic signed [15:0] r_icpt [4];
    logic signed [15:0] r_amp [4];
    logic signed [15:0] r_offs [4];
    logic [EXP_W-1:0]  r_exp [4];
    logic [CNT_W-1:0]  r_cnt [4];

    // Working registers.
    logic [7:0]        r_pix [3];
    logic [7:0]        r_alpha;
    logic [1:0]        r_ch;
    logic [7:0]        r_c;
    logic [7:0]        r_p;
    logic [EXP_W-1:0]  r_e;
    logic [IDX_W-1:0]  r_k;
    logic [7:0]        r_dist;
    logic signed [15:0] r_vk;
    logic signed [VAL_W-1:0] r_val;
    logic [7:0]        r_res [4];
    logic signed [PROD_W-1:0] r_prod;
    logic              r_o_valid;
    logic [7:0]        r_o_red, r_o_green, r_o_blue, r_o_alpha;

    logic in_acc, out_acc, out_free;
    logic [2:0]        mode_cur;
    logic [CNT_W-1:0]  cnt_cur, cnt_m1;
    logic signed [16:0] mul_a;
    logic signed [8:0]  mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic [7:0]        clamp_v;
    logic [IDX_W-1:0]  k1;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [15:0]       rd_data;
    logic [IDX_W+7:0]  wr_idx;
    t_div_req          div_req;
    t_div_rsp          div_rsp;
    t_tab_wr           tab_wr;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_acc  = r_o_valid && !i_out_stall;
    assign out_free = !r_o_valid || !i_out_stall;
    assign mode_cur = r_mode[r_ch];
    assign cnt_cur  = r_cnt[r_ch];
    assign cnt_m1   = cnt_cur - 1'b1;
    assign mul_p    = mul_a * mul_b;
    assign k1       = (CNT_W'(r_k) >= cnt_m1) ? r_k : r_k + 1'b1;
    assign wr_idx   = {{IDX_W{1'b0}}, i_table_index};

    // Clamp of the transfer result to 0..255.
    always_comb begin
        if (r_val < 0) begin
            clamp_v = 8'd0;
        end else if (r_val > VAL_W'(255)) begin
            clamp_v = 8'd255;
        end else begin
            clamp_v = r_val[7:0];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_req_type == REQ_PIXEL)) n_state = ST_UNPRE;
            end
            ST_UNPRE: begin
                if ((r_ch == 2'd3) || (r_alpha == 8'd0)) n_state = ST_XFER;
                else n_state = ST_MUL;
            end
            ST_XFER: begin
                case (mode_cur)
                    MODE_LINEAR, MODE_GAMMA: n_state = ST_MUL;
                    MODE_TABLE, MODE_DISCRETE: begin
                        n_state = (cnt_cur == '0) ? ST_CLAMP : ST_MUL;
                    end
                    default: n_state = ST_CLAMP;
                endcase
            end
            ST_MUL:    n_state = ST_DSTART;
            ST_DSTART: n_state = ST_DWAIT;
            ST_DWAIT: begin
                if (div_rsp.done) begin
                    case (r_op)
                        OP_UNPRE: n_state = ST_XFER;
                        OP_GPOW:  n_state = ST_MUL;
                        OP_TIDX, OP_DIDX: n_state = ST_RDK;
                        OP_PREM:  n_state = (r_ch == 2'd2) ? ST_DONE : ST_PREM;
                        default:  n_state = ST_CLAMP;
                    endcase
                end
            end
            ST_RDK:  n_state = (mode_cur == MODE_TABLE) ? ST_RDK1 : ST_RDW;
            ST_RDK1: n_state = ST_RDW;
            ST_RDW:  n_state = (mode_cur == MODE_TABLE) ? ST_MUL : ST_CLAMP;
            ST_CLAMP: n_state = (r_ch == 2'd3) ? ST_PREM : ST_UNPRE;
            ST_PREM:  n_state = ST_MUL;
            ST_DONE:  n_state = out_free ? ST_IDLE : ST_DONE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control outputs and multiplier operand selection.
    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        rd_en   = (r_state == ST_RDK) || (r_state == ST_RDK1);
        rd_addr = {r_ch, (r_state == ST_RDK1) ? k1 : r_k};
        div_req.start    = (r_state == ST_DSTART);
        div_req.dividend = r_prod;
        div_req.divisor  = (r_op == OP_UNPRE) ? r_alpha : 8'd255;
        tab_wr.en   = in_acc && (i_req_type == REQ_TABLE) &&
                      (wr_idx < (IDX_W + 8)'(TABLE_DEPTH));
        tab_wr.addr = {i_channel, wr_idx[IDX_W-1:0]};
        tab_wr.data = i_load_value;
        mul_b = $signed({1'b0, r_c});
        case (r_op)
            OP_UNPRE: begin
                mul_a = 17'sd255;
                mul_b = $signed({1'b0, r_pix[r_ch]});
            end
            OP_LIN:  mul_a = 17'(r_slope[r_ch]);
            OP_GPOW: mul_a = $signed({9'd0, r_p});
            OP_GAMP: begin
                mul_a = 17'(r_amp[r_ch]);
                mul_b = $signed({1'b0, r_p});
            end
            OP_TIDX: mul_a = $signed(17'(cnt_m1));
            OP_DIDX: mul_a = $signed(17'(cnt_cur));
            OP_TINT: begin
                mul_a = 17'($signed(rd_data)) - 17'(r_vk);
                mul_b = $signed({1'b0, r_dist});
            end
            OP_PREM: begin
                mul_a = $signed({9'd0, r_res[3]});
                mul_b = $signed({1'b0, r_res[r_ch]});
            end
            default: mul_a = '0;
        endcase
    end

    // Control registers and per-channel settings.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_mode[i]  <= MODE_IDENTITY;
                r_slope[i] <= '0;
                r_icpt[i]  <= '0;
                r_amp[i]   <= '0;
                r_offs[i]  <= '0;
                r_exp[i]   <= '0;
                r_cnt[i]   <= '0;
            end
        end else begin
            r_state <= n_state;
            if ((r_state == ST_DONE) && out_free) r_o_valid <= 1'b1;
            else if (out_acc) r_o_valid <= 1'b0;
            if (in_acc && (i_req_type == REQ_PARAM)) begin
                case (i_param_select)
                    SEL_MODE: begin
                        if ((i_load_value >= 0) && (i_load_value <= 16'(MODE_GAMMA)))
                            r_mode[i_channel] <= i_load_value[2:0];
                    end
                    SEL_SLOPE:     r_slope[i_channel] <= i_load_value;
                    SEL_INTERCEPT: r_icpt[i_channel]  <= i_load_value;
                    SEL_AMPLITUDE: r_amp[i_channel]   <= i_load_value;
                    SEL_OFFSET:    r_offs[i_channel]  <= i_load_value;
                    SEL_EXPONENT: begin
                        if (i_load_value < 0) r_exp[i_channel] <= '0;
                        else if (i_load_value > 16'(MAX_EXPONENT))
                            r_exp[i_channel] <= EXP_W'(MAX_EXPONENT);
                        else r_exp[i_channel] <= i_load_value[EXP_W-1:0];
                    end
                    SEL_COUNT: begin
                        if (i_load_value < 0) r_cnt[i_channel] <= '0;
                        else if (i_load_value > 16'(TABLE_DEPTH))
                            r_cnt[i_channel] <= CNT_W'(TABLE_DEPTH);
                        else r_cnt[i_channel] <= i_load_value[CNT_W-1:0];
                    end
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_ch     <= 2'd0;
                r_pix[0] <= i_in_red;
                r_pix[1] <= i_in_green;
                r_pix[2] <= i_in_blue;
                r_alpha  <= i_in_alpha;
            end
            ST_UNPRE: begin
                r_op <= OP_UNPRE;
                if (r_ch == 2'd3) r_c <= r_alpha;
                else r_c <= 8'd0;
            end
            ST_XFER: begin
                r_val <= VAL_W'($signed({1'b0, r_c}));
                r_p   <= 8'd255;
                r_e   <= r_exp[r_ch];
                case (mode_cur)
                    MODE_LINEAR:   r_op <= OP_LIN;
                    MODE_GAMMA:    r_op <= (r_exp[r_ch] == '0) ? OP_GAMP : OP_GPOW;
                    MODE_TABLE:    r_op <= OP_TIDX;
                    MODE_DISCRETE: r_op <= OP_DIDX;
                    default:       r_op <= r_op;
                endcase
            end
            ST_MUL: r_prod <= mul_p;
            ST_DWAIT: begin
                if (div_rsp.done) begin
                    case (r_op)
                        OP_UNPRE: begin
                            r_c <= (div_rsp.quot > PROD_W'(255)) ? 8'd255
                                                                   : div_rsp.quot[7:0];
                        end
                        OP_LIN: r_val <= VAL_W'(div_rsp.quot) + VAL_W'(r_icpt[r_ch]);
                        OP_GPOW: begin
                            r_p <= div_rsp.quot[7:0];
                            r_e <= r_e - 1'b1;
                            if (r_e == EXP_W'(1)) r_op <= OP_GAMP;
                        end
                        OP_GAMP: r_val <= VAL_W'(div_rsp.quot) + VAL_W'(r_offs[r_ch]);
                        OP_TIDX: begin
                            r_k    <= div_rsp.quot[IDX_W-1:0];
                            r_dist <= div_rsp.rem;
                        end
                        OP_DIDX: begin
                            if (div_rsp.quot > $signed(PROD_W'(cnt_m1)))
                                r_k <= cnt_m1[IDX_W-1:0];
                            else r_k <= div_rsp.quot[IDX_W-1:0];
                        end
                        OP_TINT: r_val <= VAL_W'(r_vk) + VAL_W'(div_rsp.quot);
                        OP_PREM: begin
                            r_res[r_ch] <= div_rsp.quot[7:0];
                            r_ch <= r_ch + 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RDK1: r_vk <= $signed(rd_data);
            ST_RDW: begin
                r_op  <= OP_TINT;
                r_val <= VAL_W'($signed(rd_data));
            end
            ST_CLAMP: begin
                r_res[r_ch] <= clamp_v;
                r_ch <= r_ch + 1'b1;
            end
            ST_PREM: r_op <= OP_PREM;
            ST_DONE: begin
                if (out_free) begin
                    r_o_red   <= r_res[0];
                    r_o_green <= r_res[1];
                    r_o_blue  <= r_res[2];
                    r_o_alpha <= r_res[3];
                end
            end
            default: ;
        endcase
    end

    // Shared divider and table store.
    rgbact_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    rgbact_table u_table (
        .i_clk     (i_clk),
        .i_wr      (tab_wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_out_valid = r_o_valid;
    assign o_out_red   = r_o_red;
    assign o_out_green = r_o_green;
    assign o_out_blue  = r_o_blue;
    assign o_out_alpha = r_o_alpha;

endmodule

// ----- hdl/rgba_component_transfer_top.sv -----
// Top level of the RGBA component transfer block.
// Parameter and table-write transactions are taken without stalling and give no result.
// A pixel transaction runs through one shared multiplier and one shared divider: a
// division by alpha (unpremultiply, skipped when alpha is zero) goes through the 25-step
// bit-serial divider, while every division by 255 (linear, each gamma step, table and
// discrete index, table interpolation, re-premultiply) uses a reciprocal multiplication.
// The input stalls while a pixel is in progress; the finished result sits in an output
// register, so the next transaction is taken while it waits.
module rgba_component_transfer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [1:0]  i_channel,
    input  logic [2:0]  i_param_select,
    input  logic [7:0]  i_table_index,
    input  logic signed [15:0] i_load_value,
    input  logic [7:0]  i_in_red,
    input  logic [7:0]  i_in_green,
    input  logic [7:0]  i_in_blue,
    input  logic [7:0]  i_in_alpha,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic [7:0]  o_out_alpha
);
    import rgbact_pkg::*;

    // Sequencer with its shared arithmetic and table store.
    rgbact_xfer_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_channel      (i_channel),
        .i_param_select (i_param_select),
        .i_table_index  (i_table_index),
        .i_load_value   (i_load_value),
        .i_in_red       (i_in_red),
        .i_in_green     (i_in_green),
        .i_in_blue      (i_in_blue),
        .i_in_alpha     (i_in_alpha),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_red      (o_out_red),
        .o_out_green    (o_out_green),
        .o_out_blue     (o_out_blue),
        .o_out_alpha    (o_out_alpha)
    );

endmodule

// ----- hdl/rgbact_checker.sv -----
// Port-level assertions for the RGBA component transfer block, bound to the top level.
module rgbact_assert (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [1:0]  i_req_type,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_out_red,
    input logic [7:0]  o_out_green,
    input logic [7:0]  o_out_blue,
    input logic [7:0]  o_out_alpha
);
    import rgbact_pkg::*;

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_red) &&
        $stable(o_out_green) && $stable(o_out_blue) && $stable(o_out_alpha))
        else $error("result changed while stalled");

    // A pixel transaction keeps the input stalled in the next cycle.
    a_pixel_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_req_type == REQ_PIXEL) |=> o_in_stall)
        else $error("input not stalled while a pixel is in progress");

    // A load or other non-pixel transaction leaves the input unstalled in the next cycle.
    a_load_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_req_type != REQ_PIXEL) |=> !o_in_stall)
        else $error("load transaction stalled the input");

    // No result appears out of reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

endmodule

bind rgba_component_transfer_top rgbact_assert u_rgbact_assert (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_req_type  (i_req_type),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_red   (o_out_red),
    .o_out_green (o_out_green),
    .o_out_blue  (o_out_blue),
    .o_out_alpha (o_out_alpha)
);

// ----- tb/rgbact_checker.sv -----
// Checker for the RGBA component transfer block: predicts pixel results and compares them.
module rgbact_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         req_type,
    input  logic [1:0]         channel,
    input  logic [2:0]         param_select,
    input  logic [7:0]         table_index,
    input  logic signed [15:0] load_value,
    input  logic [7:0]         in_red,
    input  logic [7:0]         in_green,
    input  logic [7:0]         in_blue,
    input  logic [7:0]         in_alpha,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [7:0]         out_red,
    input  logic [7:0]         out_green,
    input  logic [7:0]         out_blue,
    input  logic [7:0]         out_alpha,
    output int                 fail_count,
    output int                 pending
);
    import rgbact_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_pixel;

    // Shadow copy of the per-channel transfer settings.
    logic [2:0] xf_mode [4];
    int         xf_slope [4];
    int         xf_intercept [4];
    int         xf_amplitude [4];
    int         xf_offset [4];
    int         xf_exponent [4];
    int         xf_count [4];
    int         xf_table [4][TABLE_DEPTH];

    t_pixel expected_pixels[$];

    // Transfer function of one channel on an unpremultiplied value.
    function automatic int transfer_value(int ch, int c);
        int n, k, k1, lo, hi, frac, pw;
        n = xf_count[ch];
        case (xf_mode[ch])
            MODE_TABLE: begin
                if (n == 0) return c;
                k    = (c * (n - 1)) / 255;
                k1   = k + 1;
                if (k > n - 1) k = n - 1;
                if (k1 > n - 1) k1 = n - 1;
                lo   = xf_table[ch][k];
                hi   = xf_table[ch][k1];
                frac = (c * (n - 1)) % 255;
                return lo + frac * (hi - lo) / 255;
            end
            MODE_DISCRETE: begin
                if (n == 0) return c;
                k = (c * n) / 255;
                if (k > n - 1) k = n - 1;
                return xf_table[ch][k];
            end
            MODE_LINEAR: return xf_slope[ch] * c / 255 + xf_intercept[ch];
            MODE_GAMMA: begin
                pw = 255;
                for (int e = 0; e < xf_exponent[ch]; e++) pw = pw * c / 255;
                return xf_amplitude[ch] * pw / 255 + xf_offset[ch];
            end
            default: return c;
        endcase
    endfunction

    function automatic int clamp_byte(int v);
        if (v < 0) return 0;
        if (v > 255) return 255;
        return v;
    endfunction

    // Full pixel path: unpremultiply, transfer, clamp, premultiply.
    function automatic t_pixel transfer_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                              logic [7:0] a);
        t_pixel px;
        int colour [3];
        int res [4];
        colour[0] = r;
        colour[1] = g;
        colour[2] = b;
        for (int c = 0; c < 3; c++) begin
            int u;
            u = 0;
            if (a != 0) begin
                u = colour[c] * 255 / a;
                if (u > 255) u = 255;
            end
            res[c] = clamp_byte(transfer_value(c, u));
        end
        res[3]   = clamp_byte(transfer_value(3, a));
        px.red   = 8'(res[0] * res[3] / 255);
        px.green = 8'(res[1] * res[3] / 255);
        px.blue  = 8'(res[2] * res[3] / 255);
        px.alpha = 8'(res[3]);
        return px;
    endfunction

    task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Results are checked before the transaction of the same edge is predicted.
    always @(posedge clk) begin
        if (!rst_n) begin
            for (int ch = 0; ch < 4; ch++) begin
                xf_mode[ch]      = MODE_IDENTITY;
                xf_slope[ch]     = 0;
                xf_intercept[ch] = 0;
                xf_amplitude[ch] = 0;
                xf_offset[ch]    = 0;
                xf_exponent[ch]  = 0;
                xf_count[ch]     = 0;
                for (int i = 0; i < TABLE_DEPTH; i++) xf_table[ch][i] = 0;
            end
            expected_pixels.delete();
            fail_count = 0;
            pending    = 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_pixels.size() == 0) begin
                    $error("Result transaction with no pixel outstanding");
                    fail_count++;
                end else begin
                    t_pixel px;
                    px = expected_pixels.pop_front();
                    check_field("out_red", px.red, out_red);
                    check_field("out_green", px.green, out_green);
                    check_field("out_blue", px.blue, out_blue);
                    check_field("out_alpha", px.alpha, out_alpha);
                end
            end
            if (in_valid && !in_stall) begin
                int v;
                v = load_value;
                case (req_type)
                    REQ_PIXEL:
                        expected_pixels.push_back(transfer_pixel(in_red, in_green, in_blue,
                                                                 in_alpha));
                    REQ_PARAM:
                        case (param_select)
                            SEL_MODE:
                                if (v >= 0 && v <= MODE_GAMMA) xf_mode[channel] = 3'(v);
                            SEL_SLOPE:     xf_slope[channel] = v;
                            SEL_INTERCEPT: xf_intercept[channel] = v;
                            SEL_AMPLITUDE: xf_amplitude[channel] = v;
                            SEL_OFFSET:    xf_offset[channel] = v;
                            SEL_EXPONENT:
                                xf_exponent[channel] = v < 0 ? 0 :
                                                       (v > MAX_EXPONENT ? MAX_EXPONENT : v);
                            SEL_COUNT:
                                xf_count[channel] = v < 0 ? 0 :
                                                    (v > TABLE_DEPTH ? TABLE_DEPTH : v);
                            default: ;
                        endcase
                    REQ_TABLE:
                        if (table_index < TABLE_DEPTH) xf_table[channel][table_index] = v;
                    default: ;
                endcase
            end
            pending = expected_pixels.size();
        end
    end
endmodule

// ----- tb/tb.sv -----
// Testbench top: drives stimulus into the RGBA component transfer block and gives the verdict.
module tb;
    import rgbact_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 50000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_req_type = '0;
    logic [1:0]         i_channel = '0;
    logic [2:0]         i_param_select = '0;
    logic [7:0]         i_table_index = '0;
    logic signed [15:0] i_load_value = '0;
    logic [7:0]         i_in_red = '0;
    logic [7:0]         i_in_green = '0;
    logic [7:0]         i_in_blue = '0;
    logic [7:0]         i_in_alpha = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [7:0]         o_out_red;
    logic [7:0]         o_out_green;
    logic [7:0]         o_out_blue;
    logic [7:0]         o_out_alpha;

    int  fail_count;
    int  pending;
    bit  calm = 1'b0;
    bit  written [4][TABLE_DEPTH];
    int  n_items = 0;
    int  n_pixels = 0;
    int  quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    rgba_component_transfer_top uut (.*);

    rgbact_checker checker_i (
        .clk(i_clk), .rst_n(i_rst_n), .in_valid(i_in_valid), .in_stall(o_in_stall),
        .req_type(i_req_type), .channel(i_channel), .param_select(i_param_select),
        .table_index(i_table_index), .load_value(i_load_value), .in_red(i_in_red),
        .in_green(i_in_green), .in_blue(i_in_blue), .in_alpha(i_in_alpha),
        .out_valid(o_out_valid), .out_stall(i_out_stall), .out_red(o_out_red),
        .out_green(o_out_green), .out_blue(o_out_blue), .out_alpha(o_out_alpha),
        .fail_count(fail_count), .pending(pending)
    );

    // Random back-pressure on the result side, switched off during the calm stretch.
    always @(posedge i_clk) i_out_stall <= calm ? 1'b0 : ($urandom_range(99) < 26);

    // Watchdog: ends the run if no transaction moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Number of leading table entries of a channel that hold a written value.
    function automatic int filled_prefix(int ch);
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (!written[ch][i]) return i;
        return TABLE_DEPTH;
    endfunction

    // Presents one transaction and returns once it has been accepted.
    task automatic send(logic [1:0] req, logic [1:0] ch, logic [2:0] sel, logic [7:0] idx,
                        logic [15:0] val, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                        logic [7:0] a);
        logic stalled;
        while (!calm && $urandom_range(99) < 26) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_req_type     <= req;
        i_channel      <= ch;
        i_param_select <= sel;
        i_table_index  <= idx;
        i_load_value   <= val;
        i_in_red       <= r;
        i_in_green     <= g;
        i_in_blue      <= b;
        i_in_alpha     <= a;
        do begin
            @(negedge i_clk);
            stalled = o_in_stall;
            @(posedge i_clk);
        end while (stalled);
        if (req == REQ_TABLE) written[ch][idx] = 1'b1;
        if (req == REQ_PIXEL) n_pixels++;
        n_items++;
    endtask

    task automatic send_param(int ch, logic [2:0] sel, logic [15:0] val);
        send(REQ_PARAM, 2'(ch), sel, 8'($urandom), val, 8'($urandom), 8'($urandom),
             8'($urandom), 8'($urandom));
    endtask

    task automatic send_entry(int ch, int idx, logic [15:0] val);
        send(REQ_TABLE, 2'(ch), 3'($urandom), 8'(idx), val, 8'($urandom), 8'($urandom),
             8'($urandom), 8'($urandom));
    endtask

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
        send(REQ_PIXEL, 2'($urandom), 3'($urandom), 8'($urandom), 16'($urandom), r, g, b, a);
    endtask

    // One random parameter load that never points a table read at an unwritten entry.
    task automatic random_param();
        int ch, pick, fill;
        logic [2:0] sel;
        logic [15:0] val;
        ch  = $urandom_range(3);
        sel = 3'($urandom_range(SEL_COUNT));
        val = 16'($urandom);
        case (sel)
            SEL_MODE:
                if ($urandom_range(9) != 0) val = 16'($urandom_range(MODE_GAMMA));
            SEL_EXPONENT: begin
                pick = $urandom_range(19);
                if (pick < 14) val = 16'($urandom_range(3));
                else if (pick < 18) val = 16'($urandom_range(MAX_EXPONENT));
            end
            SEL_COUNT: begin
                fill = filled_prefix(ch);
                pick = $urandom_range(9);
                if (pick == 0) val = 16'(-$urandom_range(32768, 1));
                else if (!(fill == TABLE_DEPTH && pick < 3)) val = 16'($urandom_range(fill));
            end
            default:
                if ($urandom_range(2) == 0) val = 16'($signed($urandom_range(1020)) - 510);
        endcase
        send_param(ch, sel, val);
    endtask

    initial begin
        int pick;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: identity pixels at the extremes, including zero alpha and saturation.
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel(8'd200, 8'd10, 8'd255, 8'd100);
        // Red linear at the extremes of slope and intercept.
        send_param(0, SEL_MODE, 16'(MODE_LINEAR));
        send_param(0, SEL_SLOPE, 16'sh8000);
        send_param(0, SEL_INTERCEPT, 16'sh7fff);
        // Green table interpolation over four written entries.
        send_entry(1, 0, 16'sh8000);
        send_entry(1, 1, 16'sh7fff);
        send_entry(1, 2, 16'd128);
        send_entry(1, 3, 16'd0);
        send_param(1, SEL_COUNT, 16'd4);
        send_param(1, SEL_MODE, 16'(MODE_TABLE));
        // Blue discrete with an empty table behaves as identity.
        send_param(2, SEL_MODE, 16'(MODE_DISCRETE));
        // Alpha gamma with an exponent beyond the maximum.
        send_param(3, SEL_MODE, 16'(MODE_GAMMA));
        send_param(3, SEL_EXPONENT, 16'd100);
        send_param(3, SEL_AMPLITUDE, 16'd255);
        send_param(3, SEL_OFFSET, 16'd0);
        // Ignored loads: unknown mode, unknown selector, unknown request.
        send_param(3, SEL_MODE, 16'd7);
        send_param(2, 3'd7, 16'hffff);
        send(2'd3, 2'd1, 3'd1, 8'hff, 16'hffff, 8'hff, 8'hff, 8'hff, 8'hff);
        send_pixel(8'd90, 8'd60, 8'd30, 8'd200);
        send_pixel(8'd1, 8'd128, 8'd254, 8'd255);
        send_param(3, SEL_EXPONENT, 16'hffff);
        send_pixel(8'd40, 8'd40, 8'd40, 8'd80);

        // Random: fill the red table completely first so that counts can saturate.
        for (int i = 0; i < TABLE_DEPTH; i++) send_entry(0, i, 16'($urandom));
        while (n_items < 1500) begin
            calm = (n_items >= 500 && n_items < 650);
            if (n_items == 900) begin
                // Hold the sender back until every pixel in flight has come out.
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            pick = $urandom_range(99);
            if (pick < 42) begin
                if ($urandom_range(9) == 0)
                    send_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                               8'($urandom_range(1) * 255));
                else
                    send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            end else if (pick < 58) begin
                send_entry($urandom_range(3), $urandom_range(1) ? $urandom_range(15) :
                           $urandom_range(255), 16'($urandom));
            end else if (pick < 96) begin
                random_param();
            end else begin
                send($urandom_range(1) ? 2'd3 : REQ_PARAM, 2'($urandom), 3'd7,
                     8'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom));
            end
        end
        i_in_valid <= 1'b0;

        // Drain and let the pipeline settle.
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("Sent %0d transactions, %0d of them pixels, through all transfer modes,",
                 n_items, n_pixels);
        $display("with random idling and back-pressure on both channels.");
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
